// ===== rtl/core/lfbd_pkg.sv =====
// ============================================================================
// lfbd_pkg
// Shared types and constants for the LZSS flag-byte decoder.
// ============================================================================
package lfbd_pkg;

    localparam int WINDOW_DEPTH      = 256;
    localparam int PIXELS_PER_RESULT = 8;

    localparam int WIN_AW    = $clog2(WINDOW_DEPTH);
    localparam int CNT_W     = $clog2(PIXELS_PER_RESULT + 1);
    localparam int BUF_W     = PIXELS_PER_RESULT * 8;
    localparam int PROD_W    = 24;
    localparam int LEN_W     = 9;
    localparam int PIX_OUT_W = 64;
    localparam int CNTO_W    = 4;
    localparam int OUT_DW    = 72;

    localparam logic [LEN_W-1:0] MATCH_BASE = LEN_W'(3);
    localparam logic [LEN_W-1:0] DIST_BASE  = LEN_W'(1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_READ,
        ST_WRITE,
        ST_FLUSH
    } lfbd_state_t;

    typedef enum logic [1:0] {
        PH_FLAG,
        PH_TOKEN,
        PH_DIST
    } parse_phase_t;

    typedef enum logic [1:0] {
        DK_NONE,
        DK_LITERAL,
        DK_ERROR,
        DK_MATCH
    } decode_kind_t;

    typedef struct packed {
        logic accept;
        logic decode;
        logic read;
        logic write;
        logic flush;
    } lfbd_cmd_t;

    typedef struct packed {
        decode_kind_t kind;
        logic         copy_flush;
        logic         out_free;
        logic         last_pend;
    } lfbd_status_t;

endpackage

// ===== rtl/core/lfbd_ctrl.sv =====
// ============================================================================
// lfbd_ctrl
// Sequencer: accepts a byte, decodes it, runs match copies and result flushes.
// ============================================================================
module lfbd_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  lfbd_pkg::lfbd_status_t status,
    output lfbd_pkg::lfbd_cmd_t    cmd
);
    import lfbd_pkg::*;

    lfbd_state_t state_reg;
    lfbd_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                unique case (status.kind)
                    DK_NONE:    state_next = ST_IDLE;
                    DK_LITERAL: state_next = ST_FLUSH;
                    DK_ERROR:   state_next = ST_FLUSH;
                    DK_MATCH:   state_next = ST_READ;
                    default:    state_next = ST_IDLE;
                endcase
            end
            ST_READ:
            begin
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                state_next = status.copy_flush ? ST_FLUSH : ST_READ;
            end
            ST_FLUSH:
            begin
                if (status.out_free)
                begin
                    state_next = status.last_pend ? ST_IDLE : ST_READ;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
            end
            ST_DECODE:
            begin
                cmd.decode = 1'b1;
            end
            ST_READ:
            begin
                cmd.read = 1'b1;
            end
            ST_WRITE:
            begin
                cmd.write = 1'b1;
            end
            ST_FLUSH:
            begin
                cmd.flush = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ===== rtl/core/lfbd_datapath.sv =====
// ============================================================================
// lfbd_datapath
// Parse state, history window, pixel packing buffer and output register.
// ============================================================================
module lfbd_datapath (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  lfbd_pkg::lfbd_cmd_t                  cmd,
    output lfbd_pkg::lfbd_status_t               status,
    input  logic                                 cfg_we,
    input  logic [lfbd_pkg::PROD_W-1:0]          cfg_data,
    input  logic                                 in_start,
    input  logic [7:0]                           in_byte,
    input  logic                                 out_ready,
    output logic                                 out_valid,
    output logic [lfbd_pkg::PIX_OUT_W-1:0]       out_pixels,
    output logic [lfbd_pkg::CNTO_W-1:0]          out_count,
    output logic                                 out_last,
    output logic                                 out_done,
    output logic                                 out_err
);
    import lfbd_pkg::*;

    logic [PROD_W-1:0] total_reg;
    parse_phase_t      phase_reg;
    logic [7:0]        flag_bits_reg;
    logic [2:0]        flag_pos_reg;
    logic [7:0]        held_reg;
    logic [PROD_W-1:0] produced_reg;
    logic              halted_reg;
    logic [7:0]        byte_reg;
    logic [WIN_AW-1:0] src_reg;
    logic [LEN_W-1:0]  remain_reg;
    logic [BUF_W-1:0]  buf_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              last_reg;
    logic              err_reg;
    logic [7:0]        rd_data_reg;

    logic              out_valid_reg;
    logic [BUF_W-1:0]  out_pixels_reg;
    logic [CNT_W-1:0]  out_count_reg;
    logic              out_last_reg;
    logic              out_done_reg;
    logic              out_err_reg;

    logic [7:0]        window_mem [WINDOW_DEPTH];

    logic              ignore;
    decode_kind_t      kind;
    logic [LEN_W-1:0]  match_dist;
    logic              dist_bad;
    logic [LEN_W-1:0]  len;
    logic [PROD_W-1:0] left;
    logic [LEN_W-1:0]  len_eff;
    logic [PROD_W-1:0] src_full;
    logic [2:0]        pos_inc;
    parse_phase_t      phase_after_token;
    logic              mem_we;
    logic [7:0]        wr_data;
    logic [7:0]        pix_data;
    logic              pix_add;

    assign ignore     = halted_reg || (produced_reg >= total_reg);
    assign match_dist = LEN_W'(byte_reg) + DIST_BASE;
    assign dist_bad   = PROD_W'(match_dist) > produced_reg;
    assign len        = LEN_W'(held_reg) + MATCH_BASE;
    assign left       = total_reg - produced_reg;
    assign len_eff    = (left < PROD_W'(len)) ? left[LEN_W-1:0] : len;
    assign src_full   = produced_reg - PROD_W'(match_dist);
    assign pos_inc    = flag_pos_reg + 3'd1;
    assign phase_after_token = (pos_inc == 3'd0) ? PH_FLAG : PH_TOKEN;

    always_comb
    begin
        kind = DK_NONE;
        if (!ignore)
        begin
            unique case (phase_reg)
                PH_TOKEN: kind = flag_bits_reg[flag_pos_reg] ? DK_NONE : DK_LITERAL;
                PH_DIST:  kind = dist_bad ? DK_ERROR : DK_MATCH;
                default:  kind = DK_NONE;
            endcase
        end
    end

    assign status.kind       = kind;
    assign status.copy_flush = (cnt_reg == CNT_W'(PIXELS_PER_RESULT - 1)) ||
                               (remain_reg == LEN_W'(1));
    assign status.out_free   = !out_valid_reg || out_ready;
    assign status.last_pend  = last_reg;

    assign pix_add  = (cmd.decode && (kind == DK_LITERAL)) || cmd.write;
    assign mem_we   = pix_add;
    assign pix_data = cmd.write ? rd_data_reg : byte_reg;
    assign wr_data  = pix_data;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            window_mem[produced_reg[WIN_AW-1:0]] <= wr_data;
        end
        if (cmd.read)
        begin
            rd_data_reg <= window_mem[src_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            byte_reg <= in_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg     <= PROD_W'(1);
            phase_reg     <= PH_FLAG;
            flag_bits_reg <= '0;
            flag_pos_reg  <= '0;
            held_reg      <= '0;
            produced_reg  <= '0;
            halted_reg    <= 1'b0;
            src_reg       <= '0;
            remain_reg    <= '0;
            buf_reg       <= '0;
            cnt_reg       <= '0;
            last_reg      <= 1'b0;
            err_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                total_reg <= cfg_data;
            end
            if (cmd.accept && in_start)
            begin
                phase_reg     <= PH_FLAG;
                flag_bits_reg <= '0;
                flag_pos_reg  <= '0;
                held_reg      <= '0;
                produced_reg  <= '0;
                halted_reg    <= 1'b0;
            end
            if (cmd.decode && !ignore)
            begin
                unique case (phase_reg)
                    PH_FLAG:
                    begin
                        flag_bits_reg <= byte_reg;
                        flag_pos_reg  <= '0;
                        phase_reg     <= PH_TOKEN;
                    end
                    PH_TOKEN:
                    begin
                        if (flag_bits_reg[flag_pos_reg])
                        begin
                            held_reg  <= byte_reg;
                            phase_reg <= PH_DIST;
                        end
                        else
                        begin
                            produced_reg <= produced_reg + PROD_W'(1);
                            flag_pos_reg <= pos_inc;
                            phase_reg    <= phase_after_token;
                            last_reg     <= 1'b1;
                            err_reg      <= 1'b0;
                        end
                    end
                    PH_DIST:
                    begin
                        if (dist_bad)
                        begin
                            halted_reg <= 1'b1;
                            phase_reg  <= PH_FLAG;
                            last_reg   <= 1'b1;
                            err_reg    <= 1'b1;
                        end
                        else
                        begin
                            flag_pos_reg <= pos_inc;
                            phase_reg    <= phase_after_token;
                            remain_reg   <= len_eff;
                            src_reg      <= src_full[WIN_AW-1:0];
                            last_reg     <= 1'b0;
                            err_reg      <= 1'b0;
                        end
                    end
                    default:
                    begin
                        phase_reg <= PH_FLAG;
                    end
                endcase
            end
            if (cmd.write)
            begin
                produced_reg <= produced_reg + PROD_W'(1);
                src_reg      <= src_reg + WIN_AW'(1);
                remain_reg   <= remain_reg - LEN_W'(1);
                last_reg     <= (remain_reg == LEN_W'(1));
            end
            if (pix_add)
            begin
                for (int i = 0; i < PIXELS_PER_RESULT; i++)
                begin
                    if (cnt_reg == CNT_W'(i))
                    begin
                        buf_reg[i*8 +: 8] <= pix_data;
                    end
                end
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            if (cmd.flush)
            begin
                buf_reg <= '0;
                cnt_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.flush)
        begin
            out_pixels_reg <= buf_reg;
            out_count_reg  <= cnt_reg;
            out_last_reg   <= last_reg;
            out_done_reg   <= last_reg && !err_reg && (produced_reg >= total_reg);
            out_err_reg    <= err_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.flush)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_pixels = PIX_OUT_W'(out_pixels_reg);
    assign out_count  = CNTO_W'(out_count_reg);
    assign out_last   = out_last_reg;
    assign out_done   = out_done_reg;
    assign out_err    = out_err_reg;

endmodule

// ===== rtl/core/lzss_flag_byte_decoder_unit.sv =====
// ============================================================================
// lzss_flag_byte_decoder_unit
// LZSS decoder with flag bytes, producing packed 8-bit pixel indices.
// ============================================================================
// One compressed byte is taken per item. Flag and length bytes are only decoded,
// a literal is decoded and then flushed, a distance byte is decoded and then runs
// a read and a write per copied pixel plus one flush per result of up to 8 pixels
// (only a flush when the distance is out of range); each copied pixel is a read and
// a write of the single-port history window, which sets the copy rate. A waiting
// output result stalls the block only when the next result is ready to go.
module lzss_flag_byte_decoder_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [23:0] cfg_data,        // total_pixels
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,    // stream_byte
    input  logic        s_axis_tuser,    // image_start
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,    // pixels[63:0], pixel_count[67:64], zero pad
    output logic        m_axis_tlast,    // last
    output logic [1:0]  m_axis_tuser     // image_done[0], dist_error[1]
);
    import lfbd_pkg::*;

    lfbd_cmd_t            cmd;
    lfbd_status_t         status;
    logic [PIX_OUT_W-1:0] out_pixels;
    logic [CNTO_W-1:0]    out_count;
    logic                 out_done;
    logic                 out_err;

    assign cfg_ready = 1'b1;

    lfbd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    lfbd_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .cfg_we     (cfg_valid),
        .cfg_data   (cfg_data),
        .in_start   (s_axis_tuser),
        .in_byte    (s_axis_tdata),
        .out_ready  (m_axis_tready),
        .out_valid  (m_axis_tvalid),
        .out_pixels (out_pixels),
        .out_count  (out_count),
        .out_last   (m_axis_tlast),
        .out_done   (out_done),
        .out_err    (out_err)
    );

    assign m_axis_tdata = {{(OUT_DW - PIX_OUT_W - CNTO_W){1'b0}}, out_count, out_pixels};
    assign m_axis_tuser = {out_err, out_done};

    a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tlast && (out_count == '0)
            && (out_pixels == '0) && !m_axis_tuser[0])
        else $error("error result malformed");

    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tlast)
        else $error("image_done on non-final result");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[1] |->
            (out_count != '0) && (out_count <= CNTO_W'(PIXELS_PER_RESULT)))
        else $error("pixel_count out of range");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept |=> !s_axis_tready)
        else $error("input accepted while decoding");

endmodule

// ===== verif/lfbd_pixel_checker.sv =====
// ============================================================================
// lfbd_pixel_checker
// Watches the config, byte and pixel channels of the LZSS flag-byte decoder,
// decodes every accepted byte on its own, and compares each pixel item
// field by field with the oldest predicted one.
// ============================================================================
module lfbd_pixel_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [23:0] cfg_data,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,
    input  logic        s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [71:0] m_axis_tdata,
    input  logic        m_axis_tlast,
    input  logic [1:0]  m_axis_tuser,
    output int          fail_total,
    output int          words_pending
);
    import lfbd_pkg::*;

    typedef struct packed {
        logic [63:0] pixels;
        logic [3:0]  count;
        logic        last;
        logic        done;
        logic        dist_err;
    } pixel_word_t;

    pixel_word_t  pending_words [$];
    pixel_word_t  want;
    pixel_word_t  seen;
    int           mismatches;

    logic [23:0]  total_px;
    parse_phase_t phase;
    logic [7:0]   flags;
    logic [2:0]   tok_pos;
    logic [7:0]   held_len;
    logic [23:0]  produced;
    logic [7:0]   history [WINDOW_DEPTH];
    logic         halted;

    function automatic void next_token();
        tok_pos = tok_pos + 3'd1;
        phase   = (tok_pos == 3'd0) ? PH_FLAG : PH_TOKEN;
    endfunction

    task automatic decode_stream_byte(input logic start, input logic [7:0] b);
        logic [7:0]  run [$];
        int unsigned match_dist;
        int unsigned len;
        int unsigned src;
        int unsigned i;
        int unsigned cnt;
        pixel_word_t w;
        if (start)
        begin
            phase    = PH_FLAG;
            flags    = 8'd0;
            tok_pos  = 3'd0;
            held_len = 8'd0;
            produced = 24'd0;
            halted   = 1'b0;
        end
        if (halted || produced >= total_px)
            return;
        if (phase == PH_FLAG)
        begin
            flags   = b;
            tok_pos = 3'd0;
            phase   = PH_TOKEN;
            return;
        end
        if (phase == PH_TOKEN)
        begin
            if (flags[tok_pos])
            begin
                held_len = b;
                phase    = PH_DIST;
                return;
            end
            history[produced % WINDOW_DEPTH] = b;
            run = {run, b};
            produced = produced + 24'd1;
            next_token();
        end
        else
        begin
            match_dist = b + int'(DIST_BASE);
            len        = held_len + int'(MATCH_BASE);
            if (match_dist > 32'(produced))
            begin
                halted = 1'b1;
                phase  = PH_FLAG;
                w = '{pixels: 64'd0, count: 4'd0, last: 1'b1, done: 1'b0, dist_err: 1'b1};
                pending_words = {pending_words, w};
                return;
            end
            if (len > 32'(total_px) - 32'(produced))
                len = 32'(total_px) - 32'(produced);
            src = 32'(produced) - match_dist;
            for (i = 0; i < len; i++)
            begin
                history[produced % WINDOW_DEPTH] = history[(src + i) % WINDOW_DEPTH];
                run = {run, history[(src + i) % WINDOW_DEPTH]};
                produced = produced + 24'd1;
            end
            next_token();
        end
        i = 0;
        while (i < run.size())
        begin
            cnt = run.size() - i;
            if (cnt > PIXELS_PER_RESULT)
                cnt = PIXELS_PER_RESULT;
            w = '0;
            for (int k = 0; k < cnt; k++)
                w.pixels[8*k +: 8] = run[i + k];
            i = i + cnt;
            w.count    = cnt[3:0];
            w.last     = (i == run.size());
            w.done     = (i == run.size()) && (produced >= total_px);
            w.dist_err = 1'b0;
            pending_words = {pending_words, w};
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_words.delete();
            mismatches    = 0;
            total_px      = 24'd1;
            phase         = PH_FLAG;
            flags         = 8'd0;
            tok_pos       = 3'd0;
            held_len      = 8'd0;
            produced      = 24'd0;
            halted        = 1'b0;
            fail_total    <= 0;
            words_pending <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                total_px = cfg_data;
            if (s_axis_tvalid && s_axis_tready)
                decode_stream_byte(s_axis_tuser, s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
            begin
                seen.pixels   = m_axis_tdata[63:0];
                seen.count    = m_axis_tdata[67:64];
                seen.last     = m_axis_tlast;
                seen.done     = m_axis_tuser[0];
                seen.dist_err = m_axis_tuser[1];
                if (pending_words.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("%0t: unexpected pixel item pixels=%h count=%0d %s",
                                 $time, seen.pixels, seen.count,
                                 $sformatf("last=%b done=%b err=%b",
                                           seen.last, seen.done, seen.dist_err));
                    mismatches++;
                end
                else
                begin
                    want = pending_words.pop_front();
                    if (seen.pixels !== want.pixels || seen.count !== want.count ||
                        seen.last !== want.last || seen.done !== want.done ||
                        seen.dist_err !== want.dist_err)
                    begin
                        if (mismatches < 10)
                        begin
                            $display("%0t: pixel item mismatch: expected pixels=%h %s",
                                     $time, want.pixels,
                                     $sformatf("count=%0d last=%b done=%b err=%b",
                                               want.count, want.last, want.done,
                                               want.dist_err));
                            $display("%0t:   got pixels=%h %s",
                                     $time, seen.pixels,
                                     $sformatf("count=%0d last=%b done=%b err=%b",
                                               seen.count, seen.last, seen.done,
                                               seen.dist_err));
                        end
                        mismatches++;
                    end
                end
            end
            fail_total    <= mismatches;
            words_pending <= pending_words.size();
        end
    end

endmodule

// ===== verif/lzss_flag_byte_decoder_unit_tb.sv =====
// ============================================================================
// lzss_flag_byte_decoder_unit_tb
// Drives compressed images into the decoder with random gaps and output
// stalls, across several pixel totals; the checker predicts and compares.
// ============================================================================
module lzss_flag_byte_decoder_unit_tb;

    localparam int ITEM_TARGET  = 500;
    localparam int DRAIN_CYCLES = 16;
    localparam int IDLE_LIMIT   = 5000;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        cfg_valid     = 1'b0;
    logic        cfg_ready;
    logic [23:0] cfg_data      = 24'd0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'd0;
    logic        s_axis_tuser  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [71:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic [1:0]  m_axis_tuser;

    int          fail_total;
    int          words_pending;
    int          items_sent  = 0;
    int          idle_cycles = 0;
    int          rx_wait     = 0;
    bit          tx_quiet    = 1'b0;
    bit          rx_quiet    = 1'b0;

    // {image_start, byte}
    logic [8:0]  opening [25] = '{
        9'h1FC, 9'h000, 9'h0FF, 9'h0FF, 9'h001, 9'h000, 9'h0FF, 9'h005, 9'h010,
        9'h001, 9'h000, 9'h002, 9'h003, 9'h003, 9'h007, 9'h001, 9'h00A, 9'h000,
        9'h055, 9'h101, 9'h000, 9'h000, 9'h0FF, 9'h100, 9'h042
    };

    lzss_flag_byte_decoder_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    lfbd_pixel_checker chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .fail_total    (fail_total),
        .words_pending (words_pending)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // pixel sink with random stalls
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            rx_wait = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if ($urandom_range(0, 31) == 0)
                    rx_quiet = !rx_quiet;
                rx_wait = rx_quiet ? 0 : $urandom_range(0, 11);
            end
            if (rx_wait > 0)
            begin
                m_axis_tready <= 1'b0;
                rx_wait = rx_wait - 1;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles = idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic send_byte(input logic start, input logic [7:0] b, input bit counted);
        int gap;
        if ($urandom_range(0, 31) == 0)
            tx_quiet = !tx_quiet;
        gap = tx_quiet ? 0 : $urandom_range(0, 11);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= start;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        if (counted)
            items_sent++;
    endtask

    task automatic wait_drain();
        s_axis_tvalid <= 1'b0;
        repeat (2) @(posedge clk);
        while (words_pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_total(input logic [23:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // one image: mostly valid tokens, with rare bad distances and abandoned matches
    task automatic send_image(input int unsigned total);
        int unsigned made;
        int unsigned budget;
        int unsigned span;
        int          tok;
        logic [7:0]  flg;
        logic [7:0]  len_b;
        logic [7:0]  dist_b;
        logic        bad;
        bit          stop;
        made   = 0;
        budget = $urandom_range(4, 48);
        stop   = 1'b0;
        tok    = 0;
        flg    = 8'($urandom_range(0, 255));
        case ($urandom_range(0, 5))
            0:       flg = 8'h00;
            1:       flg = 8'hFF;
            default: ;
        endcase
        if ($urandom_range(0, 15) != 0)
            flg[0] = 1'b0;
        send_byte(1'b1, flg, 1'b1);
        while (!stop && made < total && budget > 0)
        begin
            if ($urandom_range(0, 63) == 0)
                wait_drain();
            if (tok == 8)
            begin
                flg = 8'($urandom_range(0, 255));
                send_byte(1'b0, flg, 1'b1);
                tok = 0;
            end
            else if (!flg[tok])
            begin
                send_byte(1'b0, 8'($urandom_range(0, 255)), 1'b1);
                made++;
                tok++;
                budget--;
            end
            else
            begin
                case ($urandom_range(0, 7))
                    0:       len_b = 8'hFF;
                    1:       len_b = 8'($urandom_range(0, 255));
                    default: len_b = 8'($urandom_range(0, 12));
                endcase
                send_byte(1'b0, len_b, 1'b1);
                if ($urandom_range(0, 39) == 0)
                    stop = 1'b1;
                else
                begin
                    bad = (made < 256) && (made == 0 || $urandom_range(0, 29) == 0);
                    span = (made > 256) ? 256 : made;
                    if (bad)
                        dist_b = 8'($urandom_range(made, 255));
                    else if ($urandom_range(0, 1) == 0)
                        dist_b = 8'($urandom_range(0, span - 1));
                    else
                        dist_b = 8'($urandom_range(0, ((span < 8) ? span : 8) - 1));
                    send_byte(1'b0, dist_b, 1'b1);
                    if (bad)
                    begin
                        send_byte(1'b0, 8'($urandom_range(0, 255)), 1'b0);
                        stop = 1'b1;
                    end
                    else
                    begin
                        made = (made + len_b + 3 > total) ? total : made + len_b + 3;
                        tok++;
                        budget--;
                    end
                end
            end
        end
        if (!stop && made >= total && $urandom_range(0, 1) == 1)
            send_byte(1'b0, 8'($urandom_range(0, 255)), 1'b0);
    endtask

    initial
    begin
        int          ph;
        int unsigned total;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_total(24'd290);
        for (int i = 0; i < 25; i++)
            send_byte(opening[i][8], opening[i][7:0], 1'b1);

        for (ph = 0; items_sent < ITEM_TARGET; ph++)
        begin
            wait_drain();
            case (ph)
                0: total = 1;
                1: total = 32'hFFFFFF;
                2: total = 0;
                default:
                    case ($urandom_range(0, 5))
                        0, 1, 2: total = $urandom_range(1, 64);
                        3, 4:    total = $urandom_range(65, 700);
                        default: total = $urandom_range(701, 5000);
                    endcase
            endcase
            write_total(total[23:0]);
            repeat ($urandom_range(1, 3)) send_image(total);
        end

        // total lowered mid-image, then raised again to finish it
        wait_drain();
        write_total(24'd40);
        send_byte(1'b1, 8'h00, 1'b1);
        repeat (8) send_byte(1'b0, 8'($urandom_range(0, 255)), 1'b1);
        send_byte(1'b0, 8'h00, 1'b1);
        repeat (2) send_byte(1'b0, 8'($urandom_range(0, 255)), 1'b1);
        wait_drain();
        write_total(24'd5);
        repeat (3) send_byte(1'b0, 8'($urandom_range(0, 255)), 1'b0);
        wait_drain();
        write_total(24'd12);
        repeat (2) send_byte(1'b0, 8'($urandom_range(0, 255)), 1'b1);

        wait_drain();
        if (fail_total == 0 && words_pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
